[hw/rtl/nap_pkg.sv]
package nap_pkg;

    // fixed field widths of the request, result and configuration channels
    localparam int SLOT_W     = 12;
    localparam int VALUE_W    = 60;
    localparam int GALOIS_W   = 13;
    localparam int RING_LOG_W = 4;
    localparam int CFG_IDX_W  = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GALOIS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LOG  = 2'd3;

    // request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // reset values of the configuration registers
    localparam logic [VALUE_W-1:0]    MODULUS_RST   = 60'd2;
    localparam logic [GALOIS_W-1:0]   GALOIS_RST    = 13'd1;
    localparam logic                  EVAL_MODE_RST = 1'b0;
    localparam logic [RING_LOG_W-1:0] RING_LOG_RST  = 4'd12;

endpackage

[hw/rtl/nap_ram.sv]
module nap_ram #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 60
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/negacyclic_automorphism_permuter.sv]
// a read request passes the stage 0 and stage 1 registers and the memory read register
// before its result is shown; throughput: one request per cycle while the result is not
// stalled; the slot multiply and the single-port coefficient memory each take one request a cycle
// a stalled result holds the whole three-stage pipeline
// reset clears the pipeline and loads the configuration defaults; memory
// contents are not cleared and a slot is undefined until written
module negacyclic_automorphism_permuter #(
    parameter int MAX_RING_DIM = 4096,
    parameter int COEFF_BITS   = 60
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [nap_pkg::SLOT_W-1:0]          s_slot_index,
    input  logic [nap_pkg::VALUE_W-1:0]         s_coeff_value,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [nap_pkg::VALUE_W-1:0]         m_result_value,
    output logic                                m_even_index_error,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nap_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nap_pkg::VALUE_W-1:0]         cfg_data
);

    localparam int ADDR_W = $clog2(MAX_RING_DIM);
    localparam int LG_W   = $clog2(ADDR_W + 1);
    localparam int PROD_W = ADDR_W + 1 + nap_pkg::GALOIS_W;

    // configuration
    logic [nap_pkg::VALUE_W-1:0]    modulus_reg;
    logic [nap_pkg::GALOIS_W-1:0]   galois_reg;
    logic                           eval_mode_reg;
    logic [nap_pkg::RING_LOG_W-1:0] ring_log_reg;

    // pipeline
    logic                  en;
    logic                  valid0_reg;
    logic                  kind0_reg;
    logic [ADDR_W-1:0]     idx0_reg;
    logic [COEFF_BITS-1:0] v0_reg;
    logic [ADDR_W:0]       ma0_reg;
    logic                  valid1_reg;
    logic                  kind1_reg;
    logic [ADDR_W-1:0]     idx1_reg;
    logic [COEFF_BITS-1:0] v1_reg;
    logic [PROD_W-1:0]     prod1_reg;
    logic                  m_valid_reg;
    logic                  err_reg;

    logic [LG_W-1:0]              lg_eff;
    logic [ADDR_W-1:0]            n_mask;
    logic [nap_pkg::GALOIS_W-1:0] k_val;
    logic [ADDR_W-1:0]            idx_in;
    logic [ADDR_W:0]              ma_next;
    logic [PROD_W-1:0]            prod_next;
    logic [ADDR_W-1:0]            dst;
    logic [ADDR_W-1:0]            src;
    logic                         neg;
    logic [COEFF_BITS-1:0]        wr_value;
    logic                         ram_en;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_addr;
    logic [COEFF_BITS-1:0]        ram_rdata;

    // reverse the low l bits of x
    function automatic logic [ADDR_W-1:0] rev_lg(input logic [ADDR_W-1:0] x,
                                                 input logic [LG_W-1:0] l);
        logic [ADDR_W-1:0] r;
        for (int b = 0; b < ADDR_W; b++) begin
            r[b] = x[ADDR_W-1-b];
        end
        return r >> (ADDR_W - int'(l));
    endfunction

    always_comb begin
        if (ring_log_reg == '0) begin
            lg_eff = LG_W'(1);
        end else if (int'(ring_log_reg) > ADDR_W) begin
            lg_eff = LG_W'(ADDR_W);
        end else begin
            lg_eff = LG_W'(ring_log_reg);
        end
    end

    assign n_mask = ~({ADDR_W{1'b1}} << lg_eff);
    assign k_val  = galois_reg & ~({nap_pkg::GALOIS_W{1'b1}} << (int'(lg_eff) + 1));

    // stage 0: index and multiplier operand
    assign idx_in = ADDR_W'(s_slot_index) & n_mask;

    always_comb begin
        if (s_kind == nap_pkg::KIND_READ && eval_mode_reg) begin
            ma_next = {rev_lg(idx_in, lg_eff), 1'b1};
        end else begin
            ma_next = {1'b0, idx_in};
        end
    end

    // stage 1: slot multiply
    assign prod_next = PROD_W'(ma0_reg) * PROD_W'(k_val);

    // stage 2: address, sign and memory access
    assign dst = ADDR_W'(prod1_reg) & n_mask;
    assign src = ADDR_W'(prod1_reg >> 1) & n_mask;
    assign neg = prod1_reg[lg_eff];

    always_comb begin
        wr_value = v1_reg;
        if (!eval_mode_reg && neg && v1_reg != '0) begin
            wr_value = COEFF_BITS'(modulus_reg) - v1_reg;
        end
    end

    always_comb begin
        if (kind1_reg == nap_pkg::KIND_WRITE) begin
            ram_addr = eval_mode_reg ? idx1_reg : dst;
        end else begin
            ram_addr = eval_mode_reg ? rev_lg(src, lg_eff) : idx1_reg;
        end
    end

    // writes and reads meet the memory in the same stage, in request order
    assign ram_en = en && valid1_reg;
    assign ram_we = kind1_reg == nap_pkg::KIND_WRITE;

    nap_ram #(
        .DEPTH  (MAX_RING_DIM),
        .DATA_W (COEFF_BITS)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wr_value),
        .rdata (ram_rdata)
    );

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg   <= nap_pkg::MODULUS_RST;
            galois_reg    <= nap_pkg::GALOIS_RST;
            eval_mode_reg <= nap_pkg::EVAL_MODE_RST;
            ring_log_reg  <= nap_pkg::RING_LOG_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                nap_pkg::CFG_MODULUS:   modulus_reg   <= cfg_data;
                nap_pkg::CFG_GALOIS:    galois_reg    <= cfg_data[nap_pkg::GALOIS_W-1:0];
                nap_pkg::CFG_EVAL_MODE: eval_mode_reg <= cfg_data[0];
                nap_pkg::CFG_RING_LOG:  ring_log_reg  <= cfg_data[nap_pkg::RING_LOG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg  <= 1'b0;
            valid1_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            valid0_reg  <= s_valid;
            valid1_reg  <= valid0_reg;
            m_valid_reg <= valid1_reg && kind1_reg == nap_pkg::KIND_READ;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind0_reg <= s_kind;
            idx0_reg  <= idx_in;
            v0_reg    <= COEFF_BITS'(s_coeff_value);
            ma0_reg   <= ma_next;
            kind1_reg <= kind0_reg;
            idx1_reg  <= idx0_reg;
            v1_reg    <= v0_reg;
            prod1_reg <= prod_next;
            err_reg   <= !galois_reg[0];
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_even_index_error = err_reg;
    assign m_result_value     = err_reg ? '0 : nap_pkg::VALUE_W'(ram_rdata);

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_even_index_error |-> m_result_value == '0)
        else $error("even index result carries a nonzero value");

    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        en && valid1_reg && kind1_reg == nap_pkg::KIND_WRITE |=> !m_valid_reg)
        else $error("write request produced a result");

    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        en && valid1_reg && kind1_reg == nap_pkg::KIND_READ |=> m_valid_reg)
        else $error("read request lost before the output");

endmodule

[bench/tb_negacyclic_automorphism_permuter.sv]
`timescale 1ns / 1ps

module tb_negacyclic_automorphism_permuter;

    localparam int RING_MAX    = 4096;
    localparam int LOG_MAX     = $clog2(RING_MAX);
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 40;
    localparam logic [nap_pkg::VALUE_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic                        kind;
        logic [nap_pkg::SLOT_W-1:0]  slot;
        logic [nap_pkg::VALUE_W-1:0] value;
    } perm_req_t;

    typedef struct packed {
        logic [nap_pkg::VALUE_W-1:0] value;
        logic                        even_err;
    } slot_read_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_kind = 1'b0;
    logic [nap_pkg::SLOT_W-1:0]  s_slot_index = '0;
    logic [nap_pkg::VALUE_W-1:0] s_coeff_value = '0;

    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [nap_pkg::VALUE_W-1:0] m_result_value;
    logic                        m_even_index_error;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [nap_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [nap_pkg::VALUE_W-1:0]   cfg_data = '0;

    // configuration as the block should hold it, updated on each register write
    logic [nap_pkg::VALUE_W-1:0] mod_q = nap_pkg::MODULUS_RST;
    int unsigned                 galois_raw = 32'(nap_pkg::GALOIS_RST);
    bit                          eval_sel = nap_pkg::EVAL_MODE_RST;
    int unsigned                 ring_log_raw = 32'(nap_pkg::RING_LOG_RST);

    logic [nap_pkg::VALUE_W-1:0] poly_image [RING_MAX];
    slot_read_t                  expected_reads[$];
    perm_req_t                   pending_reqs[$];

    // stimulus side bookkeeping of which physical slots hold data
    bit          ever_written [RING_MAX];
    int unsigned filled_slots[$];
    int unsigned k_inv;

    int unsigned mismatch_count = 0;
    int unsigned req_total = 0;
    int unsigned read_total = 0;
    int unsigned even_total = 0;
    int unsigned setting_total = 0;
    int unsigned cycle_count = 0;

    logic       req_accepted = 1'b0;
    perm_req_t  nxt_req;
    perm_req_t  seen_req;
    slot_read_t want;
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_left = 0;
    int unsigned stall_mode = 0;
    int unsigned rx_tick = 0;

    negacyclic_automorphism_permuter DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_slot_index      (s_slot_index),
        .s_coeff_value     (s_coeff_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_value    (m_result_value),
        .m_even_index_error(m_even_index_error),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned ring_bits();
        int unsigned l;
        l = ring_log_raw;
        if (l < 1) l = 1;
        if (l > LOG_MAX) l = LOG_MAX;
        return l;
    endfunction

    function automatic int unsigned active_k();
        return galois_raw & ((2 << ring_bits()) - 1);
    endfunction

    function automatic int unsigned reverse_bits(input int unsigned x, input int unsigned nb);
        int unsigned r;
        r = 0;
        for (int unsigned b = 0; b < nb; b++) begin
            r = (r << 1) | (x & 1);
            x = x >> 1;
        end
        return r;
    endfunction

    function automatic int unsigned dest_of_write(input int unsigned j);
        int unsigned n, idx;
        n = 1 << ring_bits();
        idx = j & (n - 1);
        if (eval_sel) return idx;
        return (idx * active_k()) & (n - 1);
    endfunction

    // bit-reversed evaluation order: slot i gathers from the image of its odd exponent
    function automatic int unsigned source_of_read(input int unsigned i);
        int unsigned lg, n, idx, odd;
        lg = ring_bits();
        n = 1 << lg;
        idx = i & (n - 1);
        if (!eval_sel) return idx;
        odd = 2 * reverse_bits(idx, lg) + 1;
        return reverse_bits(((odd * active_k()) & (2 * n - 1)) >> 1, lg);
    endfunction

    function automatic void track_permutation(input perm_req_t r);
        int unsigned lg, n, k, idx, prod;
        logic [nap_pkg::VALUE_W-1:0] v;
        slot_read_t res;
        lg = ring_bits();
        n = 1 << lg;
        k = active_k();
        idx = 32'(r.slot) & (n - 1);
        if (r.kind == nap_pkg::KIND_WRITE) begin
            v = r.value;
            if (!eval_sel) begin
                prod = idx * k;
                // odd wrap count flips the sign, zero stays zero
                if (((prod >> lg) & 1) != 0 && v != '0) v = mod_q - v;
            end
            poly_image[dest_of_write(idx)] = v;
        end else begin
            if (k % 2 == 0) begin
                res.value = '0;
                res.even_err = 1'b1;
                even_total++;
            end else begin
                res.value = poly_image[source_of_read(idx)];
                res.even_err = 1'b0;
            end
            expected_reads.insert(expected_reads.size(), res);
            read_total++;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [nap_pkg::VALUE_W-1:0] got,
                                   input logic [nap_pkg::VALUE_W-1:0] exp_val);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, exp_val);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            req_accepted <= 1'b0;
            mod_q = nap_pkg::MODULUS_RST;
            galois_raw = 32'(nap_pkg::GALOIS_RST);
            eval_sel = nap_pkg::EVAL_MODE_RST;
            ring_log_raw = 32'(nap_pkg::RING_LOG_RST);
        end else begin
            req_accepted <= s_valid && s_ready;
            if (m_valid && m_ready) begin
                if (expected_reads.size() == 0) begin
                    report_mismatch("result with no read pending", m_result_value, '0);
                end else begin
                    want = expected_reads.pop_front();
                    if (m_result_value !== want.value)
                        report_mismatch("result_value", m_result_value, want.value);
                    if (m_even_index_error !== want.even_err)
                        report_mismatch("even_index_error",
                                        nap_pkg::VALUE_W'(m_even_index_error),
                                        nap_pkg::VALUE_W'(want.even_err));
                end
            end
            if (s_valid && s_ready) begin
                seen_req = {s_kind, s_slot_index, s_coeff_value};
                track_permutation(seen_req);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    nap_pkg::CFG_MODULUS:   mod_q = cfg_data;
                    nap_pkg::CFG_GALOIS:
                        galois_raw = 32'(cfg_data[nap_pkg::GALOIS_W-1:0]);
                    nap_pkg::CFG_EVAL_MODE: eval_sel = cfg_data[0];
                    nap_pkg::CFG_RING_LOG:
                        ring_log_raw = 32'(cfg_data[nap_pkg::RING_LOG_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    // request driver: bursts of random length separated by random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = $urandom_range(1, 24);
            gap_left = 0;
        end else if (!s_valid || req_accepted) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                nxt_req = pending_reqs.pop_front();
                s_valid <= 1'b1;
                s_kind <= nxt_req.kind;
                s_slot_index <= nxt_req.slot;
                s_coeff_value <= nxt_req.value;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side backpressure, switching to a random pattern at random intervals
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(32, 200);
            end
            stall_left--;
            rx_tick++;
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (rx_tick % 3 != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads outstanding",
                     cycle_count, expected_reads.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [nap_pkg::VALUE_W-1:0] random_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[nap_pkg::VALUE_W-1:0];
    endfunction

    function automatic logic [nap_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ALL_ONES;
            2: return mod_q - nap_pkg::VALUE_W'(1);
            3: return mod_q;
            4: return random_word() % mod_q;
            default: return random_word();
        endcase
    endfunction

    function automatic int unsigned inverse_k(input int unsigned k, input int unsigned n);
        for (int unsigned u = 1; u < 2 * n; u += 2)
            if (((u * k) & (2 * n - 1)) == 1) return u;
        return 1;
    endfunction

    task automatic push_req(input logic kind, input int unsigned slot,
                            input logic [nap_pkg::VALUE_W-1:0] val);
        perm_req_t r;
        int unsigned dst;
        r.kind = kind;
        r.slot = slot[nap_pkg::SLOT_W-1:0];
        r.value = val;
        if (kind == nap_pkg::KIND_WRITE) begin
            dst = dest_of_write(slot);
            if (!ever_written[dst]) begin
                ever_written[dst] = 1'b1;
                filled_slots.insert(filled_slots.size(), dst);
            end
        end
        pending_reqs.insert(pending_reqs.size(), r);
        req_total++;
    endtask

    task automatic write_reg(input logic [nap_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nap_pkg::VALUE_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic configure(input logic [nap_pkg::VALUE_W-1:0] q, input int unsigned ge,
                             input bit ev, input int unsigned lg);
        write_reg(nap_pkg::CFG_MODULUS, q);
        write_reg(nap_pkg::CFG_GALOIS, nap_pkg::VALUE_W'(ge));
        write_reg(nap_pkg::CFG_EVAL_MODE, nap_pkg::VALUE_W'(ev));
        write_reg(nap_pkg::CFG_RING_LOG, nap_pkg::VALUE_W'(lg));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        setting_total++;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || expected_reads.size() != 0)
            @(negedge aclk);
        // trailing writes produce no result, give them time to retire
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [nap_pkg::VALUE_W-1:0] q, input int unsigned ge,
                             input bit ev, input int unsigned lg, input int count);
        int unsigned n, k, s, i, hi;
        configure(q, ge, ev, lg);
        n = 1 << ring_bits();
        k = active_k();
        filled_slots.delete();
        for (int unsigned a = 0; a < n; a++)
            if (ever_written[a]) filled_slots.insert(filled_slots.size(), a);
        if (k % 2 == 1) k_inv = inverse_k(k, n);
        repeat (count) begin
            if (filled_slots.size() == 0 || $urandom_range(0, 99) < 45) begin
                push_req(nap_pkg::KIND_WRITE, $urandom & 12'hFFF, pick_value());
            end else if (k % 2 == 0) begin
                push_req(nap_pkg::KIND_READ, $urandom & 12'hFFF, random_word());
            end else begin
                // choose a filled slot, then the read index that gathers from it
                s = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
                i = s;
                if (eval_sel)
                    i = reverse_bits(((((2 * reverse_bits(s, ring_bits())) + 1) * k_inv)
                                      & (2 * n - 1)) >> 1, ring_bits());
                hi = ($urandom_range(0, 1) == 0) ? 0 : ($urandom & 12'hFFF & ~(n - 1));
                push_req(nap_pkg::KIND_READ, hi | i, random_word());
            end
        end
        wait_drained();
    endtask

    initial begin
        logic [nap_pkg::VALUE_W-1:0] q;
        int unsigned ge, lg;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset configuration: identity map, full ring
        push_req(nap_pkg::KIND_WRITE, 0, '0);
        push_req(nap_pkg::KIND_WRITE, 4095, ALL_ONES);
        push_req(nap_pkg::KIND_WRITE, 7, 60'd1);
        push_req(nap_pkg::KIND_READ, 0, '0);
        push_req(nap_pkg::KIND_READ, 4095, ALL_ONES);
        push_req(nap_pkg::KIND_READ, 7, '0);
        wait_drained();

        // largest odd index: negation, negated zero, value above the modulus
        configure(60'd7, 8191, 1'b0, 12);
        push_req(nap_pkg::KIND_WRITE, 1, 60'd3);
        push_req(nap_pkg::KIND_WRITE, 2, '0);
        push_req(nap_pkg::KIND_WRITE, 3, 60'd9);
        push_req(nap_pkg::KIND_READ, 4095, '0);
        push_req(nap_pkg::KIND_READ, 4094, '0);
        push_req(nap_pkg::KIND_READ, 4093, '0);
        wait_drained();

        // ring log 0 acts as 1, evaluation order, indexes above n masked
        configure(ALL_ONES, 3, 1'b1, 0);
        push_req(nap_pkg::KIND_WRITE, 0, 60'd123);
        push_req(nap_pkg::KIND_WRITE, 4095, ALL_ONES);
        push_req(nap_pkg::KIND_READ, 0, '0);
        push_req(nap_pkg::KIND_READ, 4094, '0);
        push_req(nap_pkg::KIND_READ, 1, '0);
        wait_drained();

        // even indexes, ring log above the maximum
        configure(ALL_ONES, 0, 1'b0, 15);
        push_req(nap_pkg::KIND_WRITE, 5, 60'd77);
        push_req(nap_pkg::KIND_READ, 9, '0);
        wait_drained();
        configure(60'd7, 2, 1'b1, 13);
        push_req(nap_pkg::KIND_READ, 4095, '0);
        wait_drained();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 4)
                0: q = 60'd2;
                1: q = ALL_ONES;
                2: q = random_word();
                default: q = nap_pkg::VALUE_W'($urandom_range(3, 1000));
            endcase
            if (q < 2) q = 60'd2;
            case ($urandom_range(0, 3))
                0: ge = 8191;
                1: ge = $urandom & 13'h1FFE;
                default: ge = ($urandom | 1) & 13'h1FFF;
            endcase
            if (ph == 4) lg = 12;
            else if (ph == 7) lg = 15;
            else if (ph == 8) lg = 0;
            else lg = $urandom_range(1, 6);
            run_phase(q, ge, ph % 2, lg, 76);
        end

        $display("covered %0d requests and %0d reads (%0d with an even index)",
                 req_total, read_total, even_total);
        $display("over %0d register settings in both coefficient and evaluation order",
                 setting_total);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/nap_pkg.sv
hw/rtl/nap_ram.sv
hw/rtl/negacyclic_automorphism_permuter.sv
bench/tb_negacyclic_automorphism_permuter.sv
